>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cipher block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on i_clk, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check sampled on i_clk, also active during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// Types, constants and alphabet mapping functions of the Gronsfeld cipher
// ----------------------------------------------------------------------------
package gcb_pkg;

    // key geometry
    localparam int MAX_KEY_DIGITS = 16;
    localparam int DIGIT_W        = 4;
    localparam int KEY_W          = MAX_KEY_DIGITS * DIGIT_W;
    localparam int POS_W          = $clog2(MAX_KEY_DIGITS);
    localparam int LEN_W          = $clog2(MAX_KEY_DIGITS + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = KEY_W;

    // character geometry
    localparam int CP_W       = 16;
    localparam int ALPHA_SIZE = 59;
    localparam int IDX_W      = 7;
    localparam int ST_W       = 2;

    // alphabet landmarks: cyrillic A..YE, YO, ZHE..YA, then latin A..Z
    localparam logic [CP_W-1:0] CYR_FIRST = 16'h0410;
    localparam logic [CP_W-1:0] CYR_YE    = 16'h0415;
    localparam logic [CP_W-1:0] CYR_YO    = 16'h0401;
    localparam logic [CP_W-1:0] CYR_ZHE   = 16'h0416;
    localparam logic [CP_W-1:0] CYR_LAST  = 16'h042F;
    localparam logic [CP_W-1:0] LAT_FIRST = 16'h0041;
    localparam logic [CP_W-1:0] LAT_LAST  = 16'h005A;
    localparam int              YO_IDX    = 6;
    localparam int              LAT_IDX   = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_DIGITS = 1'b0,
        CFG_KEY_LENGTH = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        FUNC_ENCRYPT = 1'b0,
        FUNC_DECRYPT = 1'b1
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FOREIGN = 2'd1,
        ST_KEY_BAD = 2'd2
    } t_status;

    // key digit chosen for one item plus key validity
    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] digit;
    } t_key_sel;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_letter;

    // code point to alphabet index
    function automatic t_letter letter_index(input logic [CP_W-1:0] cp);
        t_letter         r;
        logic [CP_W-1:0] off;
        r.hit = 1'b1;
        r.idx = '0;
        off   = '0;
        if (cp >= CYR_FIRST && cp <= CYR_YE) begin
            off   = cp - CYR_FIRST;
            r.idx = off[IDX_W-1:0];
        end else if (cp == CYR_YO) begin
            r.idx = IDX_W'(YO_IDX);
        end else if (cp >= CYR_ZHE && cp <= CYR_LAST) begin
            off   = cp - CYR_ZHE + CP_W'(YO_IDX + 1);
            r.idx = off[IDX_W-1:0];
        end else if (cp >= LAT_FIRST && cp <= LAT_LAST) begin
            off   = cp - LAT_FIRST + CP_W'(LAT_IDX);
            r.idx = off[IDX_W-1:0];
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // alphabet index to code point
    function automatic logic [CP_W-1:0] letter_point(input logic [IDX_W-1:0] idx);
        logic [CP_W-1:0] cp;
        if (idx < IDX_W'(YO_IDX)) begin
            cp = CYR_FIRST + CP_W'(idx);
        end else if (idx == IDX_W'(YO_IDX)) begin
            cp = CYR_YO;
        end else if (idx < IDX_W'(LAT_IDX)) begin
            cp = CYR_ZHE + CP_W'(idx) - CP_W'(YO_IDX + 1);
        end else begin
            cp = LAT_FIRST + CP_W'(idx) - CP_W'(LAT_IDX);
        end
        return cp;
    endfunction

endpackage

>>> rtl/gcb_in_if.sv
// ----------------------------------------------------------------------------
// gcb_in_if
// Character item channel into the cipher
// ----------------------------------------------------------------------------
interface gcb_in_if;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [gcb_pkg::CP_W-1:0] code_point;
    logic                     message_start;

    modport source (output valid, func, code_point, message_start, input ready);
    modport sink   (input valid, func, code_point, message_start, output ready);
endinterface

>>> rtl/gcb_out_if.sv
// ----------------------------------------------------------------------------
// gcb_out_if
// Transformed character item channel out of the cipher
// ----------------------------------------------------------------------------
interface gcb_out_if;
    logic                     valid;
    logic                     ready;
    logic [gcb_pkg::CP_W-1:0] result_point;
    logic [gcb_pkg::ST_W-1:0] status;

    modport source (output valid, result_point, status, input ready);
    modport sink   (input valid, result_point, status, output ready);
endinterface

>>> rtl/gcb_key_ctrl.sv
// ----------------------------------------------------------------------------
// gcb_key_ctrl
// Key registers, key validity check and key position tracking
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcb_key_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_advance,
    input  logic                             i_message_start,
    output gcb_pkg::t_key_sel                o_key
);

    logic [gcb_pkg::KEY_W-1:0]   r_key_digits;
    logic [gcb_pkg::LEN_W-1:0]   r_key_len;
    logic [gcb_pkg::POS_W-1:0]   r_pos;
    logic [gcb_pkg::POS_W-1:0]   n_pos;

    logic [gcb_pkg::DIGIT_W-1:0] w_nib [gcb_pkg::MAX_KEY_DIGITS];
    logic [gcb_pkg::LEN_W-1:0]   w_len;
    logic [gcb_pkg::POS_W-1:0]   w_pos_use;
    logic [gcb_pkg::LEN_W-1:0]   w_pos_inc;
    logic                        w_any_big;
    logic                        w_any_nz;

    // split the key word into digits
    for (genvar g = 0; g < gcb_pkg::MAX_KEY_DIGITS; g++) begin : g_nib
        assign w_nib[g] = r_key_digits[g*gcb_pkg::DIGIT_W +: gcb_pkg::DIGIT_W];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_digits <= gcb_pkg::KEY_W'(1);
            r_key_len    <= gcb_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (gcb_pkg::t_cfg_reg'(i_cfg_idx))
                gcb_pkg::CFG_KEY_DIGITS: r_key_digits <= i_cfg_data[gcb_pkg::KEY_W-1:0];
                gcb_pkg::CFG_KEY_LENGTH: r_key_len    <= i_cfg_data[gcb_pkg::LEN_W-1:0];
                default:                 r_key_len    <= r_key_len;
            endcase
        end
    end

    // clamp key length into 1..max
    always_comb begin
        if (r_key_len == '0) begin
            w_len = gcb_pkg::LEN_W'(1);
        end else if (r_key_len > gcb_pkg::LEN_W'(gcb_pkg::MAX_KEY_DIGITS)) begin
            w_len = gcb_pkg::LEN_W'(gcb_pkg::MAX_KEY_DIGITS);
        end else begin
            w_len = r_key_len;
        end
    end

    // key valid: no digit above nine and at least one nonzero among digits in use
    always_comb begin
        w_any_big = 1'b0;
        w_any_nz  = 1'b0;
        for (int i = 0; i < gcb_pkg::MAX_KEY_DIGITS; i++) begin
            if (gcb_pkg::LEN_W'(i) < w_len) begin
                if (w_nib[i] > gcb_pkg::DIGIT_W'(9)) w_any_big = 1'b1;
                if (w_nib[i] != '0)                  w_any_nz  = 1'b1;
            end
        end
    end

    // position for this item and the one after it
    always_comb begin
        if (i_message_start || gcb_pkg::LEN_W'(r_pos) >= w_len) begin
            w_pos_use = '0;
        end else begin
            w_pos_use = r_pos;
        end
        w_pos_inc = gcb_pkg::LEN_W'(w_pos_use) + gcb_pkg::LEN_W'(1);
        n_pos     = (w_pos_inc >= w_len) ? '0 : w_pos_inc[gcb_pkg::POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    assign o_key.ok    = !w_any_big && w_any_nz;
    assign o_key.digit = w_nib[w_pos_use];

    `ASSERT_CLK(a_pos_wraps, i_advance |=> (gcb_pkg::LEN_W'(r_pos) < $past(w_len)), "key position not below key length after an item")
    `ASSERT_CLK(a_start_restarts, (i_advance && i_message_start && w_len > gcb_pkg::LEN_W'(1)) |=> (r_pos == gcb_pkg::POS_W'(1)), "message start did not restart key position")
    `ASSERT_CLK_ALWAYS(a_reset_pos, !i_rst_n |=> (r_pos == '0), "key position not cleared by reset")

endmodule

>>> rtl/gcb_xform.sv
// ----------------------------------------------------------------------------
// gcb_xform
// Alphabet lookup, modular shift by one key digit and reverse lookup
// ----------------------------------------------------------------------------
module gcb_xform (
    input  logic                        i_func,
    input  logic [gcb_pkg::CP_W-1:0]    i_code_point,
    input  gcb_pkg::t_key_sel           i_key,
    output logic [gcb_pkg::CP_W-1:0]    o_result_point,
    output gcb_pkg::t_status            o_status
);

    gcb_pkg::t_letter               w_letter;
    logic [gcb_pkg::IDX_W-1:0]      w_sum;
    logic [gcb_pkg::IDX_W-1:0]      w_idx;

    assign w_letter = gcb_pkg::letter_index(i_code_point);

    // shift forward or back, both sums stay below twice the alphabet size
    always_comb begin
        if (gcb_pkg::t_func'(i_func) == gcb_pkg::FUNC_ENCRYPT) begin
            w_sum = w_letter.idx + gcb_pkg::IDX_W'(i_key.digit);
        end else begin
            w_sum = w_letter.idx + gcb_pkg::IDX_W'(gcb_pkg::ALPHA_SIZE)
                  - gcb_pkg::IDX_W'(i_key.digit);
        end
        if (w_sum >= gcb_pkg::IDX_W'(gcb_pkg::ALPHA_SIZE)) begin
            w_idx = w_sum - gcb_pkg::IDX_W'(gcb_pkg::ALPHA_SIZE);
        end else begin
            w_idx = w_sum;
        end
    end

    // bad key wins over a foreign character
    always_comb begin
        if (!i_key.ok) begin
            o_status       = gcb_pkg::ST_KEY_BAD;
            o_result_point = '0;
        end else if (!w_letter.hit) begin
            o_status       = gcb_pkg::ST_FOREIGN;
            o_result_point = '0;
        end else begin
            o_status       = gcb_pkg::ST_OK;
            o_result_point = gcb_pkg::letter_point(w_idx);
        end
    end

endmodule

>>> rtl/gronsfeld_cipher_bilingual_top.sv
// ----------------------------------------------------------------------------
// gronsfeld_cipher_bilingual_top
// Bilingual Gronsfeld cipher, one character item in and one result item out
// ----------------------------------------------------------------------------
// Each input item carries one code point; the result is the code point shifted
// by the current key digit over the 59-letter alphabet (33 cyrillic capitals
// then latin A..Z), forward for encrypt and back for decrypt, with status 1 for
// a character outside the alphabet and status 2 for an invalid key. The block
// takes one item per clock while the output side is not stalled, and passes it
// through one input register feeding the lookup and modular add, then the result
// register. The key digit is chosen when the item is accepted, so the key
// position stepping is the only dependency between items. Write the key
// registers only while no item is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gronsfeld_cipher_bilingual_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gcb_in_if.sink                           i_in,
    gcb_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                          w_in_acc;
    logic                          w_s2_ready;
    gcb_pkg::t_key_sel             w_key;
    logic [gcb_pkg::CP_W-1:0]      w_result_point;
    gcb_pkg::t_status              w_status;

    logic                          r_s1_v;
    logic                          r_s1_func;
    logic [gcb_pkg::CP_W-1:0]      r_s1_cp;
    gcb_pkg::t_key_sel             r_s1_key;

    logic                          r_out_v;
    logic [gcb_pkg::CP_W-1:0]      r_out_point;
    gcb_pkg::t_status              r_out_status;

    // handshake: each stage moves when the one after it has room
    assign w_s2_ready = !r_out_v || o_out.ready;
    assign i_in.ready = !r_s1_v || w_s2_ready;
    assign w_in_acc   = i_in.valid && i_in.ready;

    gcb_key_ctrl u_key (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_advance       (w_in_acc),
        .i_message_start (i_in.message_start),
        .o_key           (w_key)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_func <= i_in.func;
            r_s1_cp   <= i_in.code_point;
            r_s1_key  <= w_key;
        end
    end

    gcb_xform u_xform (
        .i_func         (r_s1_func),
        .i_code_point   (r_s1_cp),
        .i_key          (r_s1_key),
        .o_result_point (w_result_point),
        .o_status       (w_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_v) begin
            r_out_point  <= w_result_point;
            r_out_status <= w_status;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.result_point = r_out_point;
    assign o_out.status       = r_out_status;

    `ASSERT_CLK(a_s1_holds, (r_s1_v && !w_s2_ready) |=> (r_s1_v && $stable(r_s1_cp)), "stalled input stage lost its item")
    `ASSERT_CLK(a_err_zero, (r_out_v && r_out_status != gcb_pkg::ST_OK) |-> (r_out_point == '0), "error result carries a nonzero code point")
    `ASSERT_CLK(a_s1_moves, (r_s1_v && w_s2_ready) |=> r_out_v, "input stage item not moved into result register")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilingual Gronsfeld cipher block
// ----------------------------------------------------------------------------
// Character items go in through the input channel. Each accepted item is run
// through a local model of the 59-letter shift cipher and key stepping, and
// every result item is compared in order against it. A short directed run
// covers alphabet edges, wrap-around, foreign characters and bad keys. It is
// followed by random messages under many key settings, with random idling on
// both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_ITEMS = 1100;
    localparam int LONG_HOLD    = 200;
    localparam int FLOOD_ITEMS  = 48;
    localparam int LIMIT_NS     = 20_000_000;

    typedef struct {
        logic [gcb_pkg::CP_W-1:0] point;
        gcb_pkg::t_status         status;
    } t_exp_letter;

    // local model of the cipher plus the queue of pending result items
    class t_cipher_tracker;
        logic [gcb_pkg::CP_W-1:0]  alphabet [gcb_pkg::ALPHA_SIZE];
        logic [gcb_pkg::KEY_W-1:0] key_digits;
        logic [gcb_pkg::LEN_W-1:0] key_len;
        logic [gcb_pkg::POS_W-1:0] key_pos;
        t_exp_letter               expected_letters [$];
        int unsigned               accepted;
        int unsigned               checked;
        int unsigned               fails;

        function new();
            int n;
            n = 0;
            for (int c = 'h410; c <= 'h415; c++) begin
                alphabet[n] = gcb_pkg::CP_W'(c);
                n++;
            end
            alphabet[n] = gcb_pkg::CP_W'('h401);
            n++;
            for (int c = 'h416; c <= 'h42F; c++) begin
                alphabet[n] = gcb_pkg::CP_W'(c);
                n++;
            end
            for (int c = 'h41; c <= 'h5A; c++) begin
                alphabet[n] = gcb_pkg::CP_W'(c);
                n++;
            end
            key_digits = gcb_pkg::KEY_W'(1);
            key_len    = gcb_pkg::LEN_W'(1);
            key_pos    = '0;
            accepted   = 0;
            checked    = 0;
            fails      = 0;
        endfunction

        function void write_reg(gcb_pkg::t_cfg_reg idx, logic [gcb_pkg::KEY_W-1:0] data);
            case (idx)
                gcb_pkg::CFG_KEY_DIGITS: key_digits = data;
                gcb_pkg::CFG_KEY_LENGTH: key_len    = data[gcb_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_letters.size();
        endfunction

        // zero length acts as one, anything above the digit count is clipped
        function int digits_in_use();
            if (key_len == 0)
                return 1;
            if (key_len > gcb_pkg::MAX_KEY_DIGITS)
                return gcb_pkg::MAX_KEY_DIGITS;
            return int'(key_len);
        endfunction

        function logic [gcb_pkg::DIGIT_W-1:0] digit_at(int p);
            return key_digits[p*gcb_pkg::DIGIT_W +: gcb_pkg::DIGIT_W];
        endfunction

        // any digit above nine, or all digits zero, spoils the key
        function bit key_valid(int len);
            bit any_set;
            any_set = 1'b0;
            for (int i = 0; i < len; i++) begin
                if (digit_at(i) > 9)
                    return 1'b0;
                if (digit_at(i) != 0)
                    any_set = 1'b1;
            end
            return any_set;
        endfunction

        function void note_letter(gcb_pkg::t_func f, logic [gcb_pkg::CP_W-1:0] cp,
                                  logic start);
            t_exp_letter                 e;
            int                          len;
            int                          pos;
            int                          idx;
            int                          shifted;
            logic [gcb_pkg::DIGIT_W-1:0] d;
            len = digits_in_use();
            pos = int'(key_pos);
            if (start || pos >= len)
                pos = 0;
            e.point  = '0;
            e.status = gcb_pkg::ST_OK;
            if (!key_valid(len)) begin
                e.status = gcb_pkg::ST_KEY_BAD;
            end else begin
                idx = -1;
                for (int i = 0; i < gcb_pkg::ALPHA_SIZE; i++)
                    if (alphabet[i] == cp)
                        idx = i;
                if (idx < 0) begin
                    e.status = gcb_pkg::ST_FOREIGN;
                end else begin
                    d = digit_at(pos);
                    if (f == gcb_pkg::FUNC_ENCRYPT)
                        shifted = (idx + int'(d)) % gcb_pkg::ALPHA_SIZE;
                    else
                        shifted = (idx + gcb_pkg::ALPHA_SIZE - int'(d))
                                  % gcb_pkg::ALPHA_SIZE;
                    e.point = alphabet[shifted];
                end
            end
            // position steps on every item, whatever its status
            pos++;
            if (pos >= len)
                pos = 0;
            key_pos = gcb_pkg::POS_W'(pos);
            expected_letters.insert(expected_letters.size(), e);
            accepted++;
        endfunction

        function void check_letter(logic [gcb_pkg::CP_W-1:0] point,
                                   logic [gcb_pkg::ST_W-1:0] st);
            t_exp_letter e;
            if (expected_letters.size() == 0) begin
                $error("result item with nothing pending: result_point %h status %0d",
                       point, st);
                fails++;
                return;
            end
            e = expected_letters.pop_front();
            checked++;
            if (point !== e.point) begin
                $error("result_point mismatch: expected %h, actual %h", e.point, point);
                fails++;
            end
            if (st !== gcb_pkg::ST_W'(e.status)) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, st);
                fails++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [gcb_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [gcb_pkg::CFG_DATA_W-1:0] cfg_data;
    bit                             hold_req;
    bit                             no_gaps;
    int unsigned                    settings_used;
    int unsigned                    sent;

    t_cipher_tracker tracker = new();

    gcb_in_if  in_ch ();
    gcb_out_if out_ch ();

    gronsfeld_cipher_bilingual_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("[gronsfeld_cipher_bilingual_top] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // output ready with random bursts, plus the long hold on request
    initial begin
        int left;
        bit level;
        left  = 0;
        level = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                level    = 1'b0;
                left     = LONG_HOLD;
            end else if (left > 0) begin
                left--;
            end else if (level) begin
                left = pick_gap();
                if (left > 0) begin
                    level = 1'b0;
                    left--;
                end else begin
                    left = $urandom_range(0, 29);
                end
            end else begin
                level = 1'b1;
                left  = $urandom_range(0, 29);
            end
            out_ch.ready <= level;
        end
    end

    // watch both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_letter(gcb_pkg::t_func'(in_ch.func), in_ch.code_point,
                                    in_ch.message_start);
            if (out_ch.valid && out_ch.ready)
                tracker.check_letter(out_ch.result_point, out_ch.status);
        end
    end

    task automatic send_letter(gcb_pkg::t_func f, logic [gcb_pkg::CP_W-1:0] cp,
                               logic start, int gap);
        in_ch.valid         <= 1'b1;
        in_ch.func          <= f;
        in_ch.code_point    <= cp;
        in_ch.message_start <= start;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sent++;
    endtask

    // stop offering and wait for every result item
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_reg(gcb_pkg::t_cfg_reg idx, logic [gcb_pkg::KEY_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, data);
        settings_used++;
        @(posedge i_clk);
    endtask

    // mostly well-formed keys, with zero, clipped and spoiled ones mixed in
    task automatic random_key();
        logic [gcb_pkg::KEY_W-1:0] k;
        int                        r;
        r = $urandom_range(0, 19);
        case (r)
            0: write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(0));
            1: write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(1));
            2: write_key_reg(gcb_pkg::CFG_KEY_LENGTH,
                             gcb_pkg::KEY_W'(gcb_pkg::MAX_KEY_DIGITS));
            3: write_key_reg(gcb_pkg::CFG_KEY_LENGTH,
                             gcb_pkg::KEY_W'($urandom_range(17, 31)));
            4, 5: ;
            default: write_key_reg(gcb_pkg::CFG_KEY_LENGTH,
                                   gcb_pkg::KEY_W'($urandom_range(1, 16)));
        endcase
        r = $urandom_range(0, 19);
        for (int i = 0; i < gcb_pkg::MAX_KEY_DIGITS; i++)
            k[i*gcb_pkg::DIGIT_W +: gcb_pkg::DIGIT_W] =
                gcb_pkg::DIGIT_W'($urandom_range(0, 9));
        case (r)
            0: k = '0;
            1: k = {$urandom, $urandom};
            2: k = {gcb_pkg::MAX_KEY_DIGITS{4'h9}};
            3: k[$urandom_range(0, 15)*gcb_pkg::DIGIT_W +: gcb_pkg::DIGIT_W] =
                   gcb_pkg::DIGIT_W'($urandom_range(10, 15));
            4: ;
            default: ;
        endcase
        if (r != 4)
            write_key_reg(gcb_pkg::CFG_KEY_DIGITS, k);
    endtask

    // letters mostly, then raw noise and points just off the alphabet
    function automatic logic [gcb_pkg::CP_W-1:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82)
            return tracker.alphabet[$urandom_range(0, gcb_pkg::ALPHA_SIZE - 1)];
        if (r < 92)
            return gcb_pkg::CP_W'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'h0400;
            1: return 16'h040F;
            2: return 16'h0430;
            3: return 16'h0040;
            4: return 16'h005B;
            5: return 16'h0402;
            6: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic random_message(int len);
        gcb_pkg::t_func f;
        gcb_pkg::t_func cf;
        logic           start;
        f     = gcb_pkg::t_func'($urandom_range(0, 1));
        start = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++) begin
            cf = ($urandom_range(0, 9) == 0) ? gcb_pkg::t_func'($urandom_range(0, 1)) : f;
            if (i > 0)
                start = ($urandom_range(0, 32) == 0);
            send_letter(cf, pick_point(), start, no_gaps ? 0 : pick_gap());
        end
    endtask

    // main sequence
    initial begin
        int phase;
        int budget;
        int mlen;
        phase         = 0;
        settings_used = 0;
        sent          = 0;
        hold_req      = 1'b0;
        no_gaps       = 1'b0;
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= gcb_pkg::CFG_KEY_DIGITS;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.func          <= gcb_pkg::FUNC_ENCRYPT;
        in_ch.code_point    <= '0;
        in_ch.message_start <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key: single digit one, alphabet edges and foreign points
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0041, 1'b1, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h005A, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0410, 1'b0, 1);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0401, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0416, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0415, 1'b0, 2);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h042F, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0000, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'hFFFF, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0400, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0430, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0040, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h005B, 1'b0, 0);
        drain_results();

        // five digits with a zero in use, then shorten the key mid-stream
        write_key_reg(gcb_pkg::CFG_KEY_DIGITS, 64'h0000_0000_0000_9876);
        write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(5));
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h005A, 1'b1, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h005A, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h005A, 1'b0, 0);
        drain_results();
        write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(2));
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0410, 1'b0, 0);
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0410, 1'b0, 0);
        drain_results();

        // zero length acts as one
        write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(0));
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0041, 1'b0, 0);
        drain_results();

        // oversize length with all-ones digits: bad key wins over foreign
        write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(31));
        write_key_reg(gcb_pkg::CFG_KEY_DIGITS, {gcb_pkg::KEY_W{1'b1}});
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0041, 1'b1, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0001, 1'b0, 0);
        drain_results();

        // all-zero key
        write_key_reg(gcb_pkg::CFG_KEY_DIGITS, '0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0416, 1'b0, 0);
        drain_results();

        // spoiled digit counts inside the used length, and is harmless once outside it
        write_key_reg(gcb_pkg::CFG_KEY_DIGITS, 64'hA000_0000_0000_0009);
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0042, 1'b0, 0);
        drain_results();
        write_key_reg(gcb_pkg::CFG_KEY_LENGTH, gcb_pkg::KEY_W'(1));
        send_letter(gcb_pkg::FUNC_DECRYPT, 16'h0041, 1'b1, 0);
        send_letter(gcb_pkg::FUNC_ENCRYPT, 16'h0059, 1'b0, 0);
        drain_results();

        // random messages under changing keys
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_key();
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 5) begin
                // long output stall while the input floods
                write_key_reg(gcb_pkg::CFG_KEY_LENGTH,
                              gcb_pkg::KEY_W'($urandom_range(1, 16)));
                write_key_reg(gcb_pkg::CFG_KEY_DIGITS, 64'h1234_5678_9123_4567);
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                random_message(FLOOD_ITEMS);
            end else begin
                budget = $urandom_range(10, 50);
                while (budget > 0) begin
                    mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                    random_message(mlen);
                    budget -= mlen;
                end
            end
            drain_results();
            phase++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (tracker.pending() != 0)
            $error("%0d result items never arrived", tracker.pending());
        $display("covered %0d items and %0d results over %0d register writes, %0d phases",
                 tracker.accepted, tracker.checked, settings_used, phase);
        if (tracker.fails == 0 && tracker.pending() == 0)
            $display("[gronsfeld_cipher_bilingual_top] OK");
        else
            $display("[gronsfeld_cipher_bilingual_top] ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/gcb_pkg.sv
rtl/gcb_in_if.sv
rtl/gcb_out_if.sv
rtl/gcb_key_ctrl.sv
rtl/gcb_xform.sv
rtl/gronsfeld_cipher_bilingual_top.sv
sim/testbench.sv
